// ----- rtl/core/sm4sb_pkg.sv -----
// Package for the SM4 S-box core: widths, constants, Euclid state type and affine map.
package sm4sb_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POLY_W = 9;
    localparam int unsigned DEG_W  = 4;

    localparam logic [BYTE_W-1:0] AFF_ROW    = 8'hA7;
    localparam logic [BYTE_W-1:0] AFF_CONST  = 8'hD3;
    localparam logic [POLY_W-1:0] FIELD_POLY = 9'h1F5;

    // Working set of the extended Euclidean algorithm: the current dividend and
    // divisor, each paired with its Bezout coefficient.
    typedef struct packed {
        logic [POLY_W-1:0] ra;
        logic [POLY_W-1:0] rb;
        logic [POLY_W-1:0] ya;
        logic [POLY_W-1:0] yb;
    } euclid_t;

    function automatic logic [BYTE_W-1:0] affine_map(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] row;
        logic [BYTE_W-1:0] res;
        row = AFF_ROW;
        res = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            res[i] = ^(x & row);
            row    = {row[BYTE_W-2:0], row[BYTE_W-1]};
        end
        return res ^ AFF_CONST;
    endfunction

    // Index of the highest set bit; zero for both 0 and 1.
    function automatic logic [DEG_W-1:0] poly_degree(input logic [POLY_W-1:0] v);
        logic [DEG_W-1:0] d;
        d = '0;
        for (int k = 1; k < POLY_W; k++)
        begin
            if (v[k])
            begin
                d = DEG_W'(k);
            end
        end
        return d;
    endfunction

endpackage

// ----- rtl/core/sm4sb_if.sv -----
// Valid/ready stream interfaces for the S-box input and result channels.
interface sm4sb_in_if
    import sm4sb_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface sm4sb_out_if
    import sm4sb_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] sbox_out;

    modport source (output valid, output sbox_out, input ready);
    modport sink   (input valid, input sbox_out, output ready);
endinterface

// ----- rtl/core/sm4sb_euclid_step.sv -----
// Shared shift-and-xor unit: one reduction or one remainder swap of extended Euclid.
module sm4sb_euclid_step
    import sm4sb_pkg::*;
(
    input  euclid_t cur,
    output euclid_t nxt
);

    logic [DEG_W-1:0] deg_a;
    logic [DEG_W-1:0] deg_b;
    logic [DEG_W-1:0] shift_amt;
    logic             reduce;

    assign deg_a     = poly_degree(cur.ra);
    assign deg_b     = poly_degree(cur.rb);
    assign shift_amt = deg_a - deg_b;
    assign reduce    = (cur.ra != '0) && (deg_a >= deg_b);

    always_comb
    begin
        if (reduce)
        begin
            // One quotient bit: cancel the leading term and update the coefficient alike.
            nxt.ra = cur.ra ^ (cur.rb << shift_amt);
            nxt.rb = cur.rb;
            nxt.ya = cur.ya ^ (cur.yb << shift_amt);
            nxt.yb = cur.yb;
        end
        else
        begin
            // Division finished: the divisor becomes the dividend, the remainder the divisor.
            nxt.ra = cur.rb;
            nxt.rb = cur.ra;
            nxt.ya = cur.yb;
            nxt.yb = cur.ya;
        end
    end

endmodule

// ----- rtl/core/sm4_sbox_algebraic_core.sv -----
// SM4 S-box core computing S(x) = A(inv(A(x))) with an iterative extended Euclid.
//
// Usage: one byte enters on the din channel (valid/ready) and one substituted
// byte leaves on the dout channel (valid/ready). An input request is taken
// only while the core is idle; it then holds ready low until the result has
// been computed.
// Operation: the single shared reduction unit steps through the shift-and-xor
// reductions and remainder swaps of the Euclidean algorithm over GF(2^8)
// modulo 0x1F5 and then finishes, with no reduction for an input whose affine
// image is zero. A new byte is taken only once the last one has finished, as
// that unit serves one byte at a time.
// The result sits in an output register. The core accepts the next request
// while a result still waits there; if the receiver stalls, the next result
// is held back in the working registers until the output register frees.
// Reset clears the sequencer and the output valid flag; no data is kept.
module sm4_sbox_algebraic_core
    import sm4sb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sm4sb_in_if.sink          din,
    sm4sb_out_if.source       dout
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg;
    logic              state_next;
    euclid_t           work_reg;
    euclid_t           work_next;
    euclid_t           step_out;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic [BYTE_W-1:0] out_data_next;
    logic              accept;
    logic              finish;

    sm4sb_euclid_step u_step (
        .cur (work_reg),
        .nxt (step_out)
    );

    assign din.ready     = (state_reg == ST_IDLE);
    assign accept        = din.valid && din.ready;
    assign dout.valid    = out_valid_reg;
    assign dout.sbox_out = out_data_reg;

    // The divisor reaching zero ends the algorithm; the inverse is then in ya.
    assign finish = (state_reg == ST_RUN) && (work_reg.rb == '0)
                    && (!out_valid_reg || dout.ready);

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    work_next.ra = FIELD_POLY;
                    work_next.rb = {1'b0, affine_map(din.in_byte)};
                    work_next.ya = '0;
                    work_next.yb = POLY_W'(1);
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (work_reg.rb != '0)
                begin
                    work_next = step_out;
                end
                else if (finish)
                begin
                    out_data_next  = affine_map(work_reg.ya[BYTE_W-1:0]);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/core/sm4sb_checker.sv -----
// Port-level checker for the S-box core and its bind to the top level.
module sm4sb_checker
    import sm4sb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_data
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // Once a request is taken, the core is no longer ready in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("core ready straight after taking a request");

    // A result is newly raised only when the core is back in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while core still busy");

endmodule

bind sm4_sbox_algebraic_core sm4sb_checker u_sm4sb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_data  (dout.sbox_out)
);

// ----- tb/sv/sm4_sbox_algebraic_core_tb.sv -----
// Self-checking testbench for the SM4 S-box core: directed and random bytes, scoreboard on results.
`timescale 1ns / 1ps

module sm4_sbox_algebraic_core_tb;
    import sm4sb_pkg::*;

    logic clk;
    logic rst_n;

    sm4sb_in_if  din_if ();
    sm4sb_out_if dout_if ();

    sm4_sbox_algebraic_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    logic [BYTE_W-1:0] expected_sbox[$];
    int unsigned       mismatches;
    int unsigned       requests_taken;
    int unsigned       results_seen;
    int unsigned       zero_inverse_hits;
    bit                idle_on;
    logic [BYTE_W-1:0] zero_preimage;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Index of the highest set bit; zero for both 0 and 1.
    function automatic int unsigned top_bit(input logic [31:0] v);
        int unsigned d;
        d = 0;
        for (int k = 1; k < 32; k++)
        begin
            if (v[k])
            begin
                d = k;
            end
        end
        return d;
    endfunction

    function automatic logic [BYTE_W-1:0] affine_byte(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] row;
        logic [BYTE_W-1:0] res;
        row = AFF_ROW;
        res = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            res[i] = ^(x & row);
            row    = {row[BYTE_W-2:0], row[BYTE_W-1]};
        end
        return res ^ AFF_CONST;
    endfunction

    function automatic logic [31:0] carryless_mul(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ (a << i);
            end
        end
        return acc;
    endfunction

    // Extended Euclid over GF(2) polynomials; the inverse of zero comes out as zero.
    function automatic logic [BYTE_W-1:0] gf_inverse(input logic [BYTE_W-1:0] v);
        logic [31:0] num_a;
        logic [31:0] den_b;
        logic [31:0] y_prev;
        logic [31:0] y_cur;
        logic [31:0] y_next;
        logic [31:0] quo;
        logic [31:0] rem;
        int unsigned dn;
        int unsigned dd;
        num_a  = 32'(FIELD_POLY);
        den_b  = 32'(v);
        y_prev = 32'd0;
        y_cur  = 32'd1;
        for (int guard = 0; guard < 16 && den_b != 32'd0; guard++)
        begin
            quo = '0;
            rem = num_a;
            for (int g = 0; g < 16; g++)
            begin
                if (rem == 32'd0)
                begin
                    break;
                end
                dn = top_bit(rem);
                dd = top_bit(den_b);
                if (dn < dd)
                begin
                    break;
                end
                rem = rem ^ (den_b << (dn - dd));
                quo = quo | (32'd1 << (dn - dd));
            end
            y_next = (y_prev ^ carryless_mul(quo & 32'h3FF, y_cur & 32'h3FF)) & 32'hFFFF;
            num_a  = den_b;
            den_b  = rem;
            y_prev = y_cur;
            y_cur  = y_next;
        end
        return y_prev[BYTE_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] sbox_predict(input logic [BYTE_W-1:0] x);
        return affine_byte(gf_inverse(affine_byte(x)));
    endfunction

    // Every request taken at an edge gets its expected substitution queued.
    always @(posedge clk)
    begin
        if (rst_n && din_if.valid && din_if.ready)
        begin
            expected_sbox.push_back(sbox_predict(din_if.in_byte));
            requests_taken++;
            if (affine_byte(din_if.in_byte) == '0)
            begin
                zero_inverse_hits++;
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        logic [BYTE_W-1:0] want;
        dout_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                dout_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            dout_if.ready <= 1'b1;
            do @(posedge clk); while (!dout_if.valid);
            results_seen++;
            if (expected_sbox.size() == 0)
            begin
                $display("%0t: unexpected result sbox_out=%02h, none expected", $time,
                         dout_if.sbox_out);
                mismatches++;
            end
            else
            begin
                want = expected_sbox.pop_front();
                if (dout_if.sbox_out !== want)
                begin
                    $display("%0t: sbox_out expected %02h actual %02h", $time, want,
                             dout_if.sbox_out);
                    mismatches++;
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_if.valid   <= 1'b1;
        din_if.in_byte <= b;
        do @(posedge clk); while (!din_if.ready);
    endtask

    task automatic test_directed();
        logic [BYTE_W-1:0] walk;
        idle_on = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'hFE);
        send_byte(8'h7F);
        // The byte whose affine image is zero exercises the inverse-of-zero path.
        send_byte(zero_preimage);
        send_byte(zero_preimage);
        walk = 8'h01;
        for (int i = 0; i < BYTE_W; i++)
        begin
            send_byte(walk);
            send_byte(~walk);
            walk = walk << 1;
        end
    endtask

    task automatic test_random_bytes(input int count, input bit with_idle);
        int r;
        logic [BYTE_W-1:0] b;
        idle_on = with_idle;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 15);
            if (r == 0)
            begin
                b = zero_preimage;
            end
            else if (r == 1)
            begin
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            else
            begin
                b = BYTE_W'($urandom_range(0, 255));
            end
            send_byte(b);
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        din_if.valid      <= 1'b0;
        din_if.in_byte    <= '0;
        mismatches        = 0;
        requests_taken    = 0;
        results_seen      = 0;
        zero_inverse_hits = 0;
        idle_on           = 1'b1;
        zero_preimage     = '0;
        for (int x = 0; x < 256; x++)
        begin
            if (affine_byte(x[BYTE_W-1:0]) == '0)
            begin
                zero_preimage = x[BYTE_W-1:0];
            end
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_bytes(200, 1'b0);
        test_random_bytes(1430, 1'b1);
        din_if.valid <= 1'b0;

        while (expected_sbox.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (expected_sbox.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_sbox.size());
            mismatches++;
        end

        $display("Sent %0d bytes and checked %0d results, with and without handshake gaps.",
                 requests_taken, results_seen);
        $display("Inputs mapping to a zero field element: %0d; mismatches: %0d.",
                 zero_inverse_hits, mismatches);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: run timed out", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
